[hw/rtl/ohlc_pkg.sv]
// ============================================================================
// ohlc_pkg
// Shared types and constants for the trade-to-OHLC candle aggregator.
// ============================================================================
`default_nettype none

package ohlc_pkg;

    localparam int TICK_W   = 2;
    localparam int TIME_W   = 64;
    localparam int MIN_W    = 6;
    localparam int PRICE_W  = 40;
    localparam int VOL_W    = 48;

    // tdata widths, padded to whole bytes
    localparam int IN_TDATA_W  = 160;
    localparam int OUT_TDATA_W = 280;

    // tdata bit offsets
    localparam int IN_TIME_LSB   = TICK_W;
    localparam int IN_MIN_LSB    = IN_TIME_LSB + TIME_W;
    localparam int IN_PRICE_LSB  = IN_MIN_LSB + MIN_W;
    localparam int IN_VOL_LSB    = IN_PRICE_LSB + PRICE_W;

    localparam int OUT_OPEN_LSB  = TICK_W;
    localparam int OUT_HIGH_LSB  = OUT_OPEN_LSB + PRICE_W;
    localparam int OUT_LOW_LSB   = OUT_HIGH_LSB + PRICE_W;
    localparam int OUT_CLOSE_LSB = OUT_LOW_LSB + PRICE_W;
    localparam int OUT_VOL_LSB   = OUT_CLOSE_LSB + PRICE_W;
    localparam int OUT_START_LSB = OUT_VOL_LSB + VOL_W;
    localparam int OUT_USED_W    = OUT_START_LSB + TIME_W;

    // record kinds
    localparam logic KIND_CLOSED = 1'b0;
    localparam logic KIND_LIVE   = 1'b1;

    // result queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef struct packed {
        logic [TICK_W-1:0]  ticker;
        logic [TIME_W-1:0]  time_stamp;
        logic [MIN_W-1:0]   minute;
        logic [PRICE_W-1:0] price;
        logic [VOL_W-1:0]   volume;
    } t_trade;

    typedef struct packed {
        logic               live;
        logic [MIN_W-1:0]   minute;
        logic [PRICE_W-1:0] open_p;
        logic [PRICE_W-1:0] high_p;
        logic [PRICE_W-1:0] low_p;
        logic [PRICE_W-1:0] close_p;
        logic [VOL_W-1:0]   vol_sum;
        logic [TIME_W-1:0]  start_time;
    } t_candle;

    typedef struct packed {
        logic               kind;
        logic               last;
        logic [TICK_W-1:0]  ticker;
        logic [PRICE_W-1:0] open_p;
        logic [PRICE_W-1:0] high_p;
        logic [PRICE_W-1:0] low_p;
        logic [PRICE_W-1:0] close_p;
        logic [VOL_W-1:0]   vol_sum;
        logic [TIME_W-1:0]  start_time;
    } t_result;

    typedef struct packed {
        logic accept;
        logic emit_closed;
    } t_upd_ctrl;

endpackage

`default_nettype wire

[hw/rtl/ohlc_candle_update.sv]
// ============================================================================
// ohlc_candle_update
// One-pass candle update for a single trade against its ticker's state.
// ============================================================================
`default_nettype none

module ohlc_candle_update (
    input  ohlc_pkg::t_trade                 i_trade,
    input  logic                             i_in_range,
    input  logic                             i_seen,
    input  logic [ohlc_pkg::TIME_W-1:0]      i_last_time,
    input  ohlc_pkg::t_candle                i_candle,
    output ohlc_pkg::t_upd_ctrl              o_ctrl,
    output ohlc_pkg::t_candle                o_candle,
    output ohlc_pkg::t_result                o_closed,
    output ohlc_pkg::t_result                o_live
);
    import ohlc_pkg::*;

    logic               w_stale;
    logic               w_new;
    logic [PRICE_W-1:0] w_base_high;
    logic [PRICE_W-1:0] w_base_low;
    logic [VOL_W-1:0]   w_base_vol;
    logic [VOL_W:0]     w_sum;

    assign w_stale = i_seen && (i_trade.time_stamp < i_last_time);
    assign w_new   = !i_candle.live || (i_candle.minute != i_trade.minute);

    assign o_ctrl.accept      = i_in_range && !w_stale;
    assign o_ctrl.emit_closed = i_in_range && !w_stale && w_new && i_candle.live;

    assign w_base_high = w_new ? i_trade.price : i_candle.high_p;
    assign w_base_low  = w_new ? i_trade.price : i_candle.low_p;
    assign w_base_vol  = w_new ? '0 : i_candle.vol_sum;
    assign w_sum       = {1'b0, w_base_vol} + {1'b0, i_trade.volume};

    always_comb begin
        o_candle.live       = 1'b1;
        o_candle.minute     = i_trade.minute;
        o_candle.open_p     = w_new ? i_trade.price : i_candle.open_p;
        o_candle.high_p     = (i_trade.price > w_base_high) ? i_trade.price : w_base_high;
        o_candle.low_p      = (i_trade.price < w_base_low) ? i_trade.price : w_base_low;
        o_candle.close_p    = i_trade.price;
        // saturate at all ones on carry out
        o_candle.vol_sum    = w_sum[VOL_W] ? {VOL_W{1'b1}} : w_sum[VOL_W-1:0];
        o_candle.start_time = w_new ? i_trade.time_stamp : i_candle.start_time;
    end

    always_comb begin
        o_closed.kind       = KIND_CLOSED;
        o_closed.last       = 1'b0;
        o_closed.ticker     = i_trade.ticker;
        o_closed.open_p     = i_candle.open_p;
        o_closed.high_p     = i_candle.high_p;
        o_closed.low_p      = i_candle.low_p;
        o_closed.close_p    = i_candle.close_p;
        o_closed.vol_sum    = i_candle.vol_sum;
        o_closed.start_time = i_candle.start_time;

        o_live.kind         = KIND_LIVE;
        o_live.last         = 1'b1;
        o_live.ticker       = i_trade.ticker;
        o_live.open_p       = o_candle.open_p;
        o_live.high_p       = o_candle.high_p;
        o_live.low_p        = o_candle.low_p;
        o_live.close_p      = o_candle.close_p;
        o_live.vol_sum      = o_candle.vol_sum;
        o_live.start_time   = o_candle.start_time;
    end

endmodule

`default_nettype wire

[hw/rtl/ohlc_out_fifo.sv]
// ============================================================================
// ohlc_out_fifo
// Small result queue: takes up to two results per cycle, gives one.
// ============================================================================
`default_nettype none

module ohlc_out_fifo (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push0,
    input  logic                            i_push1,
    input  ohlc_pkg::t_result               i_data0,
    input  ohlc_pkg::t_result               i_data1,
    input  logic                            i_pop,
    output logic                            o_valid,
    output ohlc_pkg::t_result               o_data,
    output logic [ohlc_pkg::QCNT_W-1:0]     o_count
);
    import ohlc_pkg::*;

    t_result             r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wp;
    logic [QPTR_W-1:0]   r_rp;
    logic [QCNT_W-1:0]   r_cnt;
    logic [QPTR_W-1:0]   w_wp1;
    logic                w_pop;

    assign w_wp1   = r_wp + QPTR_W'(1);
    assign w_pop   = i_pop && (r_cnt != '0);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wp] <= i_data0;
        end
        if (i_push1) begin
            r_mem[w_wp1] <= i_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + QPTR_W'(i_push0) + QPTR_W'(i_push1);
            r_rp  <= r_rp + QPTR_W'(w_pop);
            r_cnt <= r_cnt + QCNT_W'(i_push0) + QCNT_W'(i_push1) - QCNT_W'(w_pop);
        end
    end

endmodule

`default_nettype wire

[hw/rtl/trade_to_ohlc_candle_aggregator.sv]
// ============================================================================
// trade_to_ohlc_candle_aggregator
// Builds one-minute OHLC candles per ticker from a stream of trades.
// ============================================================================
//
// Each slave transaction carries one trade. The trade lands in an input
// register; from there it is checked against its ticker's last
// accepted timestamp, the ticker's candle is updated in a single pass and
// one or two results are written to a four-entry result queue that feeds the
// master side. A trade older than its ticker's last timestamp, or with a
// ticker at or above NUM_TICKERS, leaves no trace. When the minute changes
// the live candle is first emitted as closed (tuser 0, tlast 0), then the
// new live candle follows (tuser 1, tlast 1). A new trade is taken in every
// cycle while the queue has room for two results; results leave at one per
// cycle while the master accepts them, so the sustained rate is one trade per
// cycle when trades stay in their minute; when every trade closes a candle the
// single master port, carrying two results per trade, sets the rate. A result
// passes the input register and queue. Volume sums saturate at all ones.
//
`default_nettype none

module trade_to_ohlc_candle_aggregator #(
    parameter int NUM_TICKERS = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // tdata: ticker_index[1:0], trade_time[63:0], trade_minute[5:0],
    //        trade_price[39:0], trade_volume[47:0]
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [ohlc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tdata: out_ticker[1:0], candle_open[39:0], candle_high[39:0],
    //        candle_low[39:0], candle_close[39:0], candle_volume[47:0],
    //        candle_start_time[63:0], zero pad[5:0]
    // tuser: record_kind
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [ohlc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast
);
    import ohlc_pkg::*;

    localparam int TIX_W = (NUM_TICKERS > 1) ? $clog2(NUM_TICKERS) : 1;

    // per-ticker state
    logic                r_seen [NUM_TICKERS];
    logic [TIME_W-1:0]   r_last_time [NUM_TICKERS];
    logic                r_live [NUM_TICKERS];
    t_candle             r_candle [NUM_TICKERS];

    // input register
    logic                r_in_valid;
    t_trade              r_trade;

    logic                w_s_accept;
    logic                w_advance;
    logic                w_room;
    logic                w_pop;
    logic [8:0]          w_tick_ext;
    logic [TIX_W-1:0]    w_tix;
    logic                w_in_range;
    t_candle             w_cur;
    t_candle             w_next;
    t_upd_ctrl           w_ctrl;
    t_result             w_closed;
    t_result             w_live;
    t_result             w_q_data;
    logic                w_q_valid;
    logic [QCNT_W-1:0]   w_q_count;
    logic [QCNT_W-1:0]   w_q_after_pop;

    // hold the input register until the queue can take two results
    assign w_pop         = w_q_valid && m_axis_tready;
    assign w_q_after_pop = w_q_count - QCNT_W'(w_pop);
    assign w_room        = (w_q_after_pop <= QCNT_W'(QDEPTH - 2));
    assign w_advance     = r_in_valid && w_room;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_s_accept    = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_s_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_trade.ticker     <= s_axis_tdata[TICK_W-1:0];
            r_trade.time_stamp <= s_axis_tdata[IN_TIME_LSB +: TIME_W];
            r_trade.minute     <= s_axis_tdata[IN_MIN_LSB +: MIN_W];
            r_trade.price      <= s_axis_tdata[IN_PRICE_LSB +: PRICE_W];
            r_trade.volume     <= s_axis_tdata[IN_VOL_LSB +: VOL_W];
        end
    end

    // select the ticker's state; drop tickers beyond the table
    assign w_tick_ext = 9'(r_trade.ticker);
    assign w_tix      = w_tick_ext[TIX_W-1:0];
    assign w_in_range = (w_tick_ext < 9'(NUM_TICKERS));

    always_comb begin
        w_cur      = r_candle[w_tix];
        w_cur.live = r_live[w_tix];
    end

    ohlc_candle_update u_update (
        .i_trade     (r_trade),
        .i_in_range  (w_in_range),
        .i_seen      (r_seen[w_tix]),
        .i_last_time (r_last_time[w_tix]),
        .i_candle    (w_cur),
        .o_ctrl      (w_ctrl),
        .o_candle    (w_next),
        .o_closed    (w_closed),
        .o_live      (w_live)
    );

    // commit the update for accepted trades
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TICKERS; i++) begin
                r_seen[i] <= 1'b0;
                r_live[i] <= 1'b0;
            end
        end else if (w_advance && w_ctrl.accept) begin
            r_seen[w_tix] <= 1'b1;
            r_live[w_tix] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_ctrl.accept) begin
            r_last_time[w_tix] <= r_trade.time_stamp;
            r_candle[w_tix]    <= w_next;
        end
    end

    // closed record goes first when the minute rolls over
    ohlc_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (w_advance && w_ctrl.accept),
        .i_push1 (w_advance && w_ctrl.emit_closed),
        .i_data0 (w_ctrl.emit_closed ? w_closed : w_live),
        .i_data1 (w_live),
        .i_pop   (m_axis_tready),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .o_count (w_q_count)
    );

    assign m_axis_tvalid = w_q_valid;
    assign m_axis_tuser  = w_q_data.kind;
    assign m_axis_tlast  = w_q_data.last;

    always_comb begin
        m_axis_tdata                              = '0;
        m_axis_tdata[TICK_W-1:0]                  = w_q_data.ticker;
        m_axis_tdata[OUT_OPEN_LSB +: PRICE_W]     = w_q_data.open_p;
        m_axis_tdata[OUT_HIGH_LSB +: PRICE_W]     = w_q_data.high_p;
        m_axis_tdata[OUT_LOW_LSB +: PRICE_W]      = w_q_data.low_p;
        m_axis_tdata[OUT_CLOSE_LSB +: PRICE_W]    = w_q_data.close_p;
        m_axis_tdata[OUT_VOL_LSB +: VOL_W]        = w_q_data.vol_sum;
        m_axis_tdata[OUT_START_LSB +: TIME_W]     = w_q_data.start_time;
    end

endmodule

`default_nettype wire
